// ----- hw/rtl/bfch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfch_pkg
// shared types and defaults of the brute force convex hull block
// ----------------------------------------------------------------------------
package bfch_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAX_RD,
    ST_MAX_CMP,
    ST_SWAP0,
    ST_SWAP1,
    ST_OUTER,
    ST_CAND_CAP,
    ST_K_RD,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_H_RD,
    ST_H_CMP,
    ST_APPEND,
    ST_E_RD,
    ST_E_OUT,
    ST_E_WAIT
  } state_e;

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_POS,
    SIDE_NEG
  } side_e;

  typedef struct packed {
    logic mul_first;
    logic mul_second;
  } ori_ctrl_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } ori_res_t;

endpackage

// ----- hw/rtl/bfch_point_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfch_point_mem
// coordinate pair memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bfch_point_mem #(
  parameter int unsigned MAX_POINTS = bfch_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = bfch_pkg::CoordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(MAX_POINTS)-1:0]         waddr_i,
  input  logic signed [COORD_BITS-1:0]          wx_i,
  input  logic signed [COORD_BITS-1:0]          wy_i,
  input  logic                                  re_i,
  input  logic [$clog2(MAX_POINTS)-1:0]         raddr_i,
  output logic signed [COORD_BITS-1:0]          rx_o,
  output logic signed [COORD_BITS-1:0]          ry_o
);
  import bfch_pkg::*;

  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic [COORD_BITS-1:0] rx_q;
  logic [COORD_BITS-1:0] ry_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rx_q <= mem_x[raddr_i];
      ry_q <= mem_y[raddr_i];
    end
  end

  assign rx_o = signed'(rx_q);
  assign ry_o = signed'(ry_q);

endmodule

// ----- hw/rtl/bfch_orient_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfch_orient_unit
// shared multiplier for the orientation test, two products formed in turn
// ----------------------------------------------------------------------------
module bfch_orient_unit #(
  parameter int unsigned COORD_BITS = bfch_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  bfch_pkg::ori_ctrl_t          ctrl_i,
  input  logic signed [COORD_BITS-1:0] s_x_i,
  input  logic signed [COORD_BITS-1:0] s_y_i,
  input  logic signed [COORD_BITS-1:0] e_x_i,
  input  logic signed [COORD_BITS-1:0] e_y_i,
  input  logic signed [COORD_BITS-1:0] p_x_i,
  input  logic signed [COORD_BITS-1:0] p_y_i,
  output bfch_pkg::ori_res_t           res_o
);
  import bfch_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1_q;
  logic signed [PW-1:0] p2_q;

  always_comb begin
    if (ctrl_i.mul_second) begin
      mul_a = DW'(p_y_i) - DW'(s_y_i);
      mul_b = DW'(e_x_i) - DW'(s_x_i);
    end else begin
      mul_a = DW'(p_x_i) - DW'(s_x_i);
      mul_b = DW'(e_y_i) - DW'(s_y_i);
    end
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_first) begin
      p1_q <= prod;
    end
    if (ctrl_i.mul_second) begin
      p2_q <= prod;
    end
  end

  assign res_o.pos = p1_q > p2_q;
  assign res_o.neg = p1_q < p2_q;

endmodule

// ----- hw/rtl/brute_force_convex_hull.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brute_force_convex_hull
// brute force convex hull of a set of signed points, one shared multiplier
// ----------------------------------------------------------------------------
// Points are taken one per transfer until one with last_point set; the block
// then stalls its input, computes the hull and sends the hull vertices in the
// order found, hull_last on the final one. For n stored points each
// orientation test reads a point, forms two products on the one shared
// multiplier and compares them, with up to n tests per candidate, n candidates
// per step and one step per hull vertex, after a search for the rightmost
// point; each result is read back from the hull memory and then sent. Points
// past MAX_POINTS are dropped and reported on points_dropped.
module brute_force_convex_hull #(
  parameter int unsigned MAX_POINTS = bfch_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = bfch_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         point_valid_i,
  output logic                         point_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  output logic                         hull_valid_o,
  input  logic                         hull_stall_i,
  output logic signed [COORD_BITS-1:0] hull_x_o,
  output logic signed [COORD_BITS-1:0] hull_y_o,
  output logic                         hull_last_o,
  output logic                         points_dropped_o
);
  import bfch_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);

  state_e state_q, state_d;
  side_e  side_q;

  logic [CW-1:0] count_q, i_q, k_q, h_q, len_q;
  logic          ovf_q;
  logic [IW-1:0] best_q;
  logic signed [COORD_BITS-1:0] best_x_q, best_y_q, old_x_q, old_y_q;
  logic signed [COORD_BITS-1:0] from_x_q, from_y_q, cand_x_q, cand_y_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic out_valid_q, out_last_q, out_drop_q;

  logic                         in_xfer;
  logic                         pm_we, pm_re, hm_we, hm_re;
  logic [IW-1:0]                pm_waddr, pm_raddr, hm_waddr, hm_raddr;
  logic signed [COORD_BITS-1:0] pm_wx, pm_wy, hm_wx, hm_wy;
  logic signed [COORD_BITS-1:0] pm_rx, pm_ry, hm_rx, hm_ry;
  ori_ctrl_t                    ori_ctrl;
  ori_res_t                     ori_res;
  logic                         ori_fail, hull_match;

  assign in_xfer    = point_valid_i && !point_stall_o;
  assign ori_fail   = (ori_res.pos && side_q == SIDE_NEG) ||
                      (ori_res.neg && side_q == SIDE_POS);
  assign hull_match = (hm_rx == cand_x_q) && (hm_ry == cand_y_q);

  bfch_point_mem #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_store (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wx_i   (pm_wx),
    .wy_i   (pm_wy),
    .re_i   (pm_re),
    .raddr_i(pm_raddr),
    .rx_o   (pm_rx),
    .ry_o   (pm_ry)
  );

  bfch_point_mem #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_hull (
    .clk_i  (clk_i),
    .we_i   (hm_we),
    .waddr_i(hm_waddr),
    .wx_i   (hm_wx),
    .wy_i   (hm_wy),
    .re_i   (hm_re),
    .raddr_i(hm_raddr),
    .rx_o   (hm_rx),
    .ry_o   (hm_ry)
  );

  bfch_orient_unit #(.COORD_BITS(COORD_BITS)) u_orient (
    .clk_i (clk_i),
    .ctrl_i(ori_ctrl),
    .s_x_i (from_x_q),
    .s_y_i (from_y_q),
    .e_x_i (cand_x_q),
    .e_y_i (cand_y_q),
    .p_x_i (pm_rx),
    .p_y_i (pm_ry),
    .res_o (ori_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_xfer && last_point_i) state_d = ST_MAX_RD;
      ST_MAX_RD:   state_d = ST_MAX_CMP;
      ST_MAX_CMP:  state_d = (i_q + CW'(1) >= count_q) ? ST_SWAP0 : ST_MAX_RD;
      ST_SWAP0:    state_d = ST_SWAP1;
      ST_SWAP1:    state_d = ST_OUTER;
      ST_OUTER:    state_d = (i_q >= count_q) ? ST_E_RD : ST_CAND_CAP;
      ST_CAND_CAP: state_d = ST_K_RD;
      ST_K_RD:     state_d = ST_MUL1;
      ST_MUL1:     state_d = ST_MUL2;
      ST_MUL2:     state_d = ST_CMP;
      ST_CMP: begin
        priority if (ori_fail) begin
          state_d = ST_OUTER;
        end else if (k_q + CW'(1) >= count_q) begin
          state_d = ST_H_RD;
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_H_RD:     state_d = (h_q >= len_q) ? ST_APPEND : ST_H_CMP;
      ST_H_CMP:    state_d = hull_match ? ST_OUTER : ST_H_RD;
      ST_APPEND:   state_d = ST_OUTER;
      ST_E_RD:     state_d = ST_E_OUT;
      ST_E_OUT:    state_d = ST_E_WAIT;
      ST_E_WAIT: begin
        if (!hull_stall_i) state_d = out_last_q ? ST_IDLE : ST_E_RD;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory and multiplier controls
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = count_q[IW-1:0];
    pm_wx    = point_x_i;
    pm_wy    = point_y_i;
    pm_re    = 1'b0;
    pm_raddr = i_q[IW-1:0];
    hm_we    = 1'b0;
    hm_waddr = len_q[IW-1:0];
    hm_wx    = cand_x_q;
    hm_wy    = cand_y_q;
    hm_re    = 1'b0;
    hm_raddr = h_q[IW-1:0];
    ori_ctrl = '0;
    unique case (state_q)
      ST_IDLE:   pm_we = in_xfer && (count_q < MaxCnt);
      ST_MAX_RD: pm_re = 1'b1;
      ST_SWAP0: begin
        pm_we    = 1'b1;
        pm_waddr = '0;
        pm_wx    = best_x_q;
        pm_wy    = best_y_q;
      end
      ST_SWAP1: begin
        pm_we    = 1'b1;
        pm_waddr = best_q;
        pm_wx    = old_x_q;
        pm_wy    = old_y_q;
        hm_we    = 1'b1;
        hm_waddr = '0;
        hm_wx    = best_x_q;
        hm_wy    = best_y_q;
      end
      ST_OUTER:  pm_re = i_q < count_q;
      ST_K_RD: begin
        pm_re    = 1'b1;
        pm_raddr = k_q[IW-1:0];
      end
      ST_MUL1:   ori_ctrl.mul_first = 1'b1;
      ST_MUL2:   ori_ctrl.mul_second = 1'b1;
      ST_H_RD:   hm_re = h_q < len_q;
      ST_APPEND: hm_we = len_q < MaxCnt;
      ST_E_RD:   hm_re = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= SIDE_NONE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (count_q < MaxCnt) count_q <= count_q + CW'(1);
            else                  ovf_q   <= 1'b1;
          end
          i_q <= '0;
        end
        ST_MAX_CMP: begin
          if (i_q == '0) begin
            old_x_q  <= pm_rx;
            old_y_q  <= pm_ry;
            best_x_q <= pm_rx;
            best_y_q <= pm_ry;
            best_q   <= '0;
          end else if (pm_rx > best_x_q) begin
            best_x_q <= pm_rx;
            best_y_q <= pm_ry;
            best_q   <= i_q[IW-1:0];
          end
          i_q <= i_q + CW'(1);
        end
        ST_SWAP1: begin
          len_q    <= CW'(1);
          from_x_q <= best_x_q;
          from_y_q <= best_y_q;
          i_q      <= CW'(1);
          h_q      <= '0;
        end
        ST_OUTER: h_q <= '0;
        ST_CAND_CAP: begin
          cand_x_q <= pm_rx;
          cand_y_q <= pm_ry;
          k_q      <= '0;
          side_q   <= SIDE_NONE;
        end
        ST_CMP: begin
          if (ori_fail) begin
            i_q <= i_q + CW'(1);
          end else begin
            if (side_q == SIDE_NONE && ori_res.pos) side_q <= SIDE_POS;
            if (side_q == SIDE_NONE && ori_res.neg) side_q <= SIDE_NEG;
            k_q <= k_q + CW'(1);
          end
          h_q <= '0;
        end
        ST_H_CMP: begin
          if (hull_match) i_q <= i_q + CW'(1);
          else            h_q <= h_q + CW'(1);
        end
        ST_APPEND: begin
          if (len_q < MaxCnt) begin
            len_q    <= len_q + CW'(1);
            from_x_q <= cand_x_q;
            from_y_q <= cand_y_q;
            i_q      <= CW'(1);
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        ST_E_OUT: begin
          out_x_q     <= hm_rx;
          out_y_q     <= hm_ry;
          out_last_q  <= (h_q + CW'(1) == len_q);
          out_drop_q  <= ovf_q;
          out_valid_q <= 1'b1;
        end
        ST_E_WAIT: begin
          if (!hull_stall_i) begin
            out_valid_q <= 1'b0;
            h_q         <= h_q + CW'(1);
            if (out_last_q) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              len_q   <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign point_stall_o    = state_q != ST_IDLE;
  assign hull_valid_o     = out_valid_q;
  assign hull_x_o         = out_x_q;
  assign hull_y_o         = out_y_q;
  assign hull_last_o      = out_last_q;
  assign points_dropped_o = out_drop_q;

  a_valid_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_E_WAIT)
    else $error("result valid outside the send state");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_stall_o |-> !hull_valid_o)
    else $error("input ready while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt && len_q <= MaxCnt)
    else $error("point or hull count beyond capacity");

  a_hull_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWAP1 |=> len_q == CW'(1))
    else $error("hull not started with one vertex");

endmodule

// ----- bench/tb_brute_force_convex_hull.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brute_force_convex_hull
// self-checking bench for the brute force convex hull block
// ----------------------------------------------------------------------------
// Point sets are sent with random gaps and random back-pressure on the hull
// side. A scoreboard keeps its own copy of each point set, works out the
// hull in discovery order when the last point is taken, and compares every
// hull transfer with the oldest expected vertex. Sets cover single points,
// duplicates, collinear points, ties on the greatest x, coordinate extremes,
// random sets and one set past capacity.
// ----------------------------------------------------------------------------
module tb_brute_force_convex_hull;

  localparam int unsigned NumPts = bfch_pkg::MaxPointsDef;
  localparam int unsigned CBits = bfch_pkg::CoordBitsDef;
  localparam int unsigned CycleLimit = 4000000;

  typedef logic signed [CBits-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     dropped;
  } vertex_t;

  class hull_scoreboard;
    longint  set_x[NumPts];
    longint  set_y[NumPts];
    int      hull_idx[NumPts];
    int      hull_len;
    int      set_count;
    bit      overflow;
    vertex_t hull_q[$];
    int      errors;
    int      vertices_seen;
    int      sets_done;

    function new();
      set_count = 0;
      overflow = 0;
      errors = 0;
      vertices_seen = 0;
      sets_done = 0;
    endfunction

    function int side_of(int s, int e, int p);
      longint t1;
      longint t2;
      t1 = (set_x[p] - set_x[s]) * (set_y[e] - set_y[s]);
      t2 = (set_y[p] - set_y[s]) * (set_x[e] - set_x[s]);
      return (t1 > t2) ? 1 : ((t1 < t2) ? -1 : 0);
    endfunction

    function bit one_sided(int s, int e, int n);
      int side;
      int o;
      side = 0;
      for (int k = 0; k < n; k++) begin
        o = side_of(s, e, k);
        if (o != 0) begin
          if (side == 0) side = o;
          else if (o != side) return 0;
        end
      end
      return 1;
    endfunction

    function bit already_in_hull(int c);
      for (int h = 0; h < hull_len; h++)
        if (set_x[hull_idx[h]] == set_x[c] && set_y[hull_idx[h]] == set_y[c]) return 1;
      return 0;
    endfunction

    function void build_hull(int n);
      int     best;
      int     i;
      longint t;
      vertex_t v;
      best = 0;
      for (i = 1; i < n; i++)
        if (set_x[i] > set_x[best]) best = i;
      t = set_x[0]; set_x[0] = set_x[best]; set_x[best] = t;
      t = set_y[0]; set_y[0] = set_y[best]; set_y[best] = t;
      hull_idx[0] = 0;
      hull_len = 1;
      i = 1;
      while (i < n) begin
        if (one_sided(hull_idx[hull_len-1], i, n) && !already_in_hull(i)
            && hull_len < NumPts) begin
          hull_idx[hull_len] = i;
          hull_len++;
          i = 1;
        end else begin
          i++;
        end
      end
      for (int h = 0; h < hull_len; h++) begin
        v.x = coord_t'(set_x[hull_idx[h]]);
        v.y = coord_t'(set_y[hull_idx[h]]);
        v.last = (h + 1 == hull_len);
        v.dropped = overflow;
        hull_q = {hull_q, v};
      end
    endfunction

    function void note_point(coord_t x, coord_t y, bit last);
      if (set_count < NumPts) begin
        set_x[set_count] = longint'(x);
        set_y[set_count] = longint'(y);
        set_count++;
      end else begin
        overflow = 1;
      end
      if (last) begin
        build_hull(set_count);
        set_count = 0;
        overflow = 0;
        sets_done++;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(coord_t x, coord_t y, bit last, bit dropped);
      vertex_t v;
      vertices_seen++;
      if (hull_q.size() == 0) begin
        report($sformatf("unexpected hull vertex (%0d,%0d)", x, y));
      end else begin
        v = hull_q.pop_front();
        if (x !== v.x) report($sformatf("hull_x %0d, want %0d", x, v.x));
        if (y !== v.y) report($sformatf("hull_y %0d, want %0d", y, v.y));
        if (last !== v.last) report($sformatf("hull_last %0b, want %0b", last, v.last));
        if (dropped !== v.dropped)
          report($sformatf("points_dropped %0b, want %0b", dropped, v.dropped));
      end
    endtask

    function int pending();
      return hull_q.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   point_valid_i;
  logic   point_stall_o;
  coord_t point_x_i;
  coord_t point_y_i;
  logic   last_point_i;
  logic   hull_valid_o;
  logic   hull_stall_i;
  coord_t hull_x_o;
  coord_t hull_y_o;
  logic   hull_last_o;
  logic   points_dropped_o;

  hull_scoreboard sb;
  bit             quiet;
  int             points_sent;
  longint         cycles;

  brute_force_convex_hull DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .point_valid_i   (point_valid_i),
    .point_stall_o   (point_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .last_point_i    (last_point_i),
    .hull_valid_o    (hull_valid_o),
    .hull_stall_i    (hull_stall_i),
    .hull_x_o        (hull_x_o),
    .hull_y_o        (hull_y_o),
    .hull_last_o     (hull_last_o),
    .points_dropped_o(points_dropped_o)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // hull side: random stall, then check each transfer
  initial begin
    int g;
    hull_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      g = quiet ? 0 : $urandom_range(0, 11);
      if (g > 0) begin
        hull_stall_i <= 1;
        repeat (g) @(posedge clk_i);
        hull_stall_i <= 0;
      end
      @(posedge clk_i);
      while (!(hull_valid_o === 1'b1 && hull_stall_i === 1'b0)) @(posedge clk_i);
      sb.check_result(hull_x_o, hull_y_o, hull_last_o, points_dropped_o);
    end
  end

  task send_point(coord_t x, coord_t y, bit last);
    int g;
    g = quiet ? 0 : $urandom_range(0, 11);
    if (g > 0) begin
      point_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    point_valid_i <= 1;
    point_x_i <= x;
    point_y_i <= y;
    last_point_i <= last;
    @(posedge clk_i);
    while (point_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_point(x, y, last);
    points_sent++;
  endtask

  function coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom_range(0, 65535));
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task send_random_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(span), rand_coord(span), i == n - 1);
  endtask

  initial begin
    sb = new();
    quiet = 0;
    points_sent = 0;
    rst_ni = 0;
    point_valid_i = 0;
    point_x_i = '0;
    point_y_i = '0;
    last_point_i = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // single point at the negative corner
    send_point(-16'sd32768, -16'sd32768, 1);
    // corners of the coordinate range, ties on greatest x
    send_point(-16'sd32768, 16'sd32767, 0);
    send_point(16'sd32767, -16'sd32768, 0);
    send_point(16'sd32767, 16'sd32767, 0);
    send_point(-16'sd32768, -16'sd32768, 1);
    // all points equal
    send_point(16'sd5, 16'sd5, 0);
    send_point(16'sd5, 16'sd5, 0);
    send_point(16'sd5, 16'sd5, 1);
    // collinear with duplicates
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd2, 16'sd2, 0);
    send_point(16'sd1, 16'sd1, 0);
    send_point(16'sd2, 16'sd2, 0);
    send_point(-16'sd3, -16'sd3, 1);
    // square with interior point and edge point
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd4, 16'sd0, 0);
    send_point(16'sd4, 16'sd4, 0);
    send_point(16'sd0, 16'sd4, 0);
    send_point(16'sd2, 16'sd2, 0);
    send_point(16'sd4, 16'sd2, 1);

    // random sets, some with no idling at all
    while (points_sent < 65) begin
      quiet = ($urandom_range(0, 4) == 0);
      send_random_set($urandom_range(1, 10), ($urandom_range(0, 1) == 1) ? 0 : 4);
    end
    quiet = 0;

    // set past capacity, last point dropped
    send_random_set(NumPts + 2, 0);
    send_random_set(6, 0);

    point_valid_i <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d points in %0d sets, %0d hull vertices checked",
             points_sent, sb.sets_done, sb.vertices_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
